// File: hw/rtl/fbfla_pkg.sv
package fbfla_pkg;

    localparam int unsigned KIND_W             = 2;
    localparam int unsigned REQ_W              = 32;
    localparam int unsigned BLK_OUT_W          = 8;
    localparam int unsigned NUM_BLOCKS_W       = 9;
    localparam int unsigned MAX_BLOCKS_DEFAULT = 256;
    localparam int unsigned BLOCK_BYTES        = 1024;
    localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_RESET = 9'd256;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_POP
    } state_t;

    typedef struct packed {
        logic sweep_en;
        logic init_load;
        logic alloc_pop;
        logic free_push;
        logic out_load;
        logic out_fail;
    } cmd_t;

    typedef struct packed {
        logic head_empty;
        logic oversize;
        logic sweep_last;
        logic out_busy;
    } stat_t;

endpackage

// File: hw/rtl/fbfla_ram.sv
module fbfla_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/fbfla_ctrl.sv
module fbfla_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fbfla_pkg::KIND_W-1:0]  s_kind,
    input  logic                          m_ready,
    input  fbfla_pkg::stat_t              stat,
    output fbfla_pkg::cmd_t               cmd
);
    import fbfla_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            ST_SWEEP: begin
                cmd.sweep_en = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = !stat.out_busy || m_ready;
                accept  = s_valid && s_ready;
                if (accept) begin
                    case (kind_t'(s_kind))
                        KIND_ALLOC: begin
                            if (stat.oversize || stat.head_empty) begin
                                cmd.out_load = 1'b1;
                                cmd.out_fail = 1'b1;
                            end else begin
                                state_next = ST_POP;
                            end
                        end
                        KIND_FREE: begin
                            cmd.free_push = 1'b1;
                            cmd.out_load  = 1'b1;
                        end
                        KIND_INIT: begin
                            cmd.init_load = 1'b1;
                            cmd.out_load  = 1'b1;
                            state_next    = ST_SWEEP;
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                cmd.alloc_pop = 1'b1;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

endmodule

// File: hw/rtl/fbfla_dp.sv
module fbfla_dp #(
    parameter int unsigned MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [fbfla_pkg::REQ_W-1:0]         s_request_size,
    input  logic [fbfla_pkg::BLK_OUT_W-1:0]     s_block_index,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [fbfla_pkg::BLK_OUT_W-1:0]     m_granted_block,
    output logic                                m_status,
    input  logic                                cfg_we,
    input  logic [fbfla_pkg::NUM_BLOCKS_W-1:0]  cfg_wdata,
    input  fbfla_pkg::cmd_t                     cmd,
    output fbfla_pkg::stat_t                    stat
);
    import fbfla_pkg::*;

    localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
    localparam int unsigned LINK_W  = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned N_RESET = (32'(NUM_BLOCKS_RESET) > MAX_BLOCKS) ?
                                      MAX_BLOCKS : 32'(NUM_BLOCKS_RESET);
    localparam logic [LINK_W-1:0] EMPTY    = LINK_W'(MAX_BLOCKS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

    logic [NUM_BLOCKS_W-1:0] num_blocks_reg;
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [LINK_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic                    m_valid_reg, m_valid_next;
    logic [BLK_OUT_W-1:0]    granted_reg, granted_next;
    logic                    status_reg, status_next;

    logic [LINK_W-1:0]       n_sat;
    logic [LINK_W-1:0]       sweep_succ;
    logic                    free_ok;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [LINK_W-1:0]       ram_wdata;
    logic [LINK_W-1:0]       ram_rdata;

    fbfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (IDX_W'(head_reg)),
        .rdata (ram_rdata)
    );

    assign n_sat      = (32'(num_blocks_reg) > MAX_BLOCKS) ? EMPTY : LINK_W'(num_blocks_reg);
    assign sweep_succ = LINK_W'(cnt_reg) + LINK_W'(1);
    assign free_ok    = 32'(s_block_index) < MAX_BLOCKS;

    always_comb begin
        if (cmd.sweep_en) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
            ram_wdata = (sweep_succ < n_reg) ? sweep_succ : EMPTY;
        end else begin
            ram_we    = cmd.free_push && free_ok;
            ram_waddr = IDX_W'(s_block_index);
            ram_wdata = head_reg;
        end
    end

    always_comb begin
        head_next    = head_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        granted_next = granted_reg;
        status_next  = status_reg;
        if (cmd.sweep_en) begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
        if (cmd.init_load) begin
            n_next    = n_sat;
            head_next = (n_sat == '0) ? EMPTY : '0;
            cnt_next  = '0;
        end
        if (cmd.free_push && free_ok) begin
            head_next = LINK_W'(s_block_index);
        end
        if (cmd.alloc_pop) begin
            head_next    = ram_rdata;
            m_valid_next = 1'b1;
            granted_next = BLK_OUT_W'(head_reg);
            status_next  = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            granted_next = '0;
            status_next  = cmd.out_fail;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_blocks_reg <= NUM_BLOCKS_RESET;
            head_reg       <= '0;
            n_reg          <= LINK_W'(N_RESET);
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                num_blocks_reg <= cfg_wdata;
            end
            head_reg    <= head_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    assign stat.head_empty = head_reg >= EMPTY;
    assign stat.oversize   = s_request_size > REQ_W'(BLOCK_BYTES);
    assign stat.sweep_last = cnt_reg == LAST_IDX;
    assign stat.out_busy   = m_valid_reg;

    assign m_valid         = m_valid_reg;
    assign m_granted_block = granted_reg;
    assign m_status        = status_reg;

endmodule

// File: hw/rtl/fixed_block_free_list_allocator.sv
// Fixed-size block allocator with a LIFO free list held in a link RAM.
// Input channel (s_valid/s_ready): s_kind selects alloc, free or init;
// s_request_size is checked against the block size on alloc; s_block_index
// is pushed on free. Every transfer on the input yields exactly one transfer
// on the result channel (m_valid/m_ready): m_granted_block and m_status.
// A successful alloc passes through ST_POP, where the registered link RAM
// read gives the new head, and its result is then registered; failed alloc,
// free and init results appear in the cycle after the transfer. Frees are
// taken one per cycle while the result channel is not stalled; an alloc
// holds off the next request while it is in ST_POP. Init rebuilds the list
// by writing every link entry, one per cycle, and the input is held off
// until the rebuild completes. Reset runs the same rebuild with num_blocks
// at 256; s_ready stays low until it completes. cfg_we/cfg_wdata load
// num_blocks, which takes effect at the next init.
// A stalled result holds in the output register; the next item is taken in
// the cycle that result is transferred.
module fixed_block_free_list_allocator #(
    parameter int unsigned MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fbfla_pkg::KIND_W-1:0]        s_kind,
    input  logic [fbfla_pkg::REQ_W-1:0]         s_request_size,
    input  logic [fbfla_pkg::BLK_OUT_W-1:0]     s_block_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fbfla_pkg::BLK_OUT_W-1:0]     m_granted_block,
    output logic                                m_status,
    input  logic                                cfg_we,
    input  logic [fbfla_pkg::NUM_BLOCKS_W-1:0]  cfg_wdata
);
    import fbfla_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fbfla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fbfla_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_request_size  (s_request_size),
        .s_block_index   (s_block_index),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_granted_block (m_granted_block),
        .m_status        (m_status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

// File: hw/rtl/fbfla_checker.sv
module fbfla_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [fbfla_pkg::KIND_W-1:0]        s_kind,
    input logic [fbfla_pkg::REQ_W-1:0]         s_request_size,
    input logic [fbfla_pkg::BLK_OUT_W-1:0]     s_block_index,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [fbfla_pkg::BLK_OUT_W-1:0]     m_granted_block,
    input logic                                m_status,
    input logic                                cfg_we,
    input logic [fbfla_pkg::NUM_BLOCKS_W-1:0]  cfg_wdata
);
    import fbfla_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_request_size, s_block_index, cfg_we, cfg_wdata};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_block) && $stable(m_status))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_granted_block == '0)
        else $error("failed alloc reports a block");

    a_rebuild_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("input ready during list rebuild");

    a_non_alloc_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind != KIND_ALLOC
        |=> m_valid && m_granted_block == '0 && !m_status)
        else $error("free/init result missing or wrong");

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_fbfla_checker (.*);
